@@ src/epvf_pkg.sv @@
// ----------------------------------------------------------------------------
// epvf_pkg
// Shared types and constants for the encoder position and velocity filter.
// ----------------------------------------------------------------------------
package epvf_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int MS_PER_S        = 1000;
  localparam int COEFF_ONE       = 65536;
  localparam int COEFF_W         = 17;
  localparam int VEL_W           = 32;
  localparam int SMOOTH_W        = 48;
  localparam int ACC_W           = 50;
  localparam int PROD_W          = 51;

  typedef enum logic [1:0] {
    REQ_EDGE = 2'd0,
    REQ_VEL  = 2'd1,
    REQ_CLR  = 2'd2,
    REQ_NOP  = 2'd3
  } req_type_t;

  typedef enum logic {
    REG_FILTER_COEFF     = 1'b0,
    REG_INVERT_DIRECTION = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic       capture;
    logic       diff;
    logic       scale;
    logic       div_step;
    logic       saturate;
    logic       mac_en;
    logic [1:0] mac_step;
    logic       commit;
  } epvf_cmd_t;

  typedef struct packed {
    logic      dt_zero;
  } epvf_status_t;

endpackage

@@ src/epvf_ctrl.sv @@
// ----------------------------------------------------------------------------
// epvf_ctrl
// Sequencer for one word: decode, divide, filter and hand off the result.
// ----------------------------------------------------------------------------
module epvf_ctrl import epvf_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   req_type,
  output logic         out_valid,
  input  logic         out_stall,
  input  epvf_status_t status,
  output epvf_cmd_t    cmd
);

  localparam int MAG_W = COUNT_WIDTH + 10;
  localparam int CNT_W = $clog2(MAG_W);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIFF  = 7'b0000010,
    S_SCALE = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_SAT   = 7'b0010000,
    S_MAC   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              accept;
  logic              slot_free;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (req_type_t'(req_type) == REQ_VEL) begin
            state_next = S_DIFF;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        cnt_next   = '0;
        state_next = status.dt_zero ? S_MAC : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          state_next = S_SAT;
        end
      end
      S_SAT: begin
        cmd.saturate = 1'b1;
        cnt_next     = '0;
        state_next   = S_MAC;
      end
      S_MAC: begin
        cmd.mac_en   = 1'b1;
        cmd.mac_step = cnt[1:0];
        cnt_next     = cnt + 1'b1;
        if (cnt[1:0] == 2'd3) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/epvf_dp.sv @@
// ----------------------------------------------------------------------------
// epvf_dp
// Position counter, restoring divider, shared filter multiplier and output
// registers.
// ----------------------------------------------------------------------------
module epvf_dp import epvf_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  epvf_cmd_t           cmd,
  output epvf_status_t        status,
  input  logic [COEFF_W-1:0]  filter_coeff,
  input  logic                invert_direction,
  input  logic [1:0]          req_type,
  input  logic                phase_b,
  input  logic [31:0]         timestamp,
  output logic signed [31:0]  position,
  output logic signed [31:0]  filtered_velocity
);

  localparam int MAG_W = COUNT_WIDTH + 10;

  req_type_t                   req_q;
  logic                        phase_q;
  logic [31:0]                 time_q;

  logic [COUNT_WIDTH-1:0]      count;
  logic [COUNT_WIDTH-1:0]      count_next;
  logic [COUNT_WIDTH-1:0]      previous_count;
  logic [31:0]                 previous_time;
  logic signed [VEL_W-1:0]     raw_velocity;
  logic signed [SMOOTH_W-1:0]  smoothed_velocity;

  logic [31:0]                 dt;
  logic [COUNT_WIDTH-1:0]      dp;
  logic                        dt_zero;
  logic                        neg;
  logic [COUNT_WIDTH-1:0]      dp_abs;
  logic [MAG_W-1:0]            quo;
  logic [63:0]                 quo_wide;
  logic [32:0]                 rem;
  logic [32:0]                 rem_shift;
  logic                        rem_ge;

  logic [COEFF_W-1:0]          coeff_c;
  logic [COEFF_W-1:0]          coeff_d;
  logic [COEFF_W-1:0]          mul_a;
  logic signed [32:0]          mul_b;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc;

  logic signed [SMOOTH_W-1:0]  vel_src;
  logic signed [31:0]          vel_round;

  assign status.dt_zero = dt_zero;

  assign dp_abs    = dp[COUNT_WIDTH-1] ? (~dp + 1'b1) : dp;
  assign rem_shift = {rem[31:0], quo[MAG_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, dt});
  assign quo_wide  = 64'(quo);

  assign coeff_c = (filter_coeff > COEFF_W'(COEFF_ONE)) ? COEFF_W'(COEFF_ONE) : filter_coeff;
  assign coeff_d = COEFF_W'(COEFF_ONE) - coeff_c;

  always_comb begin
    case (cmd.mac_step)
      2'd0: begin
        mul_a = coeff_c;
        mul_b = {raw_velocity[VEL_W-1], raw_velocity};
      end
      2'd1: begin
        mul_a = coeff_d;
        mul_b = {smoothed_velocity[SMOOTH_W-1], smoothed_velocity[SMOOTH_W-1:16]};
      end
      default: begin
        mul_a = coeff_d;
        mul_b = {17'b0, smoothed_velocity[15:0]};
      end
    endcase
  end

  always_comb begin
    case (req_q)
      REQ_EDGE: begin
        if (phase_q ^ invert_direction) begin
          count_next = count + 1'b1;
        end else begin
          count_next = count - 1'b1;
        end
      end
      REQ_CLR:  count_next = '0;
      default:  count_next = count;
    endcase
  end

  assign vel_src   = (req_q == REQ_VEL) ? acc[SMOOTH_W-1:0] : smoothed_velocity;
  assign vel_round = vel_src[SMOOTH_W-1:16]
                   + 32'(vel_src[SMOOTH_W-1] && (vel_src[15:0] != 16'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      count             <= '0;
      previous_count    <= '0;
      previous_time     <= '0;
      raw_velocity      <= '0;
      smoothed_velocity <= '0;
      req_q             <= REQ_NOP;
      dt_zero           <= 1'b0;
    end else begin
      if (cmd.capture) begin
        req_q <= req_type_t'(req_type);
      end
      if (cmd.diff) begin
        dt_zero <= (time_q == previous_time);
      end
      if (cmd.saturate) begin
        if (quo_wide[63:31] != '0) begin
          raw_velocity <= neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (neg) begin
          raw_velocity <= -$signed({1'b0, quo_wide[30:0]});
        end else begin
          raw_velocity <= $signed({1'b0, quo_wide[30:0]});
        end
      end
      if (cmd.commit) begin
        count <= count_next;
        if (req_q == REQ_VEL) begin
          smoothed_velocity <= acc[SMOOTH_W-1:0];
          previous_count    <= count;
          previous_time     <= time_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      phase_q <= phase_b;
      time_q  <= timestamp;
    end
    if (cmd.diff) begin
      dt <= time_q - previous_time;
      dp <= count - previous_count;
    end
    if (cmd.scale) begin
      neg <= dp[COUNT_WIDTH-1];
      quo <= {10'b0, dp_abs} * MAG_W'(MS_PER_S);
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? (rem_shift - {1'b0, dt}) : rem_shift;
      quo <= {quo[MAG_W-2:0], rem_ge};
    end
    if (cmd.mac_en) begin
      prod <= $signed({1'b0, mul_a}) * mul_b;
      case (cmd.mac_step)
        2'd1:    acc <= prod[ACC_W-1:0];
        2'd2:    acc <= acc + prod[ACC_W-1:0];
        2'd3:    acc <= acc + $signed({16'b0, prod[ACC_W-1:16]});
        default: acc <= acc;
      endcase
    end
    if (cmd.commit) begin
      position          <= 32'($signed(count_next));
      filtered_velocity <= vel_round;
    end
  end

endmodule

@@ src/encoder_position_velocity_filter_core.sv @@
// ----------------------------------------------------------------------------
// encoder_position_velocity_filter_core
// Quadrature edge counter with a divided raw velocity and a first-order
// low-pass filter; every input word returns position and filtered velocity.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | req_type, phase_b, timestamp
//  output   | out_valid / out_stall| position, filtered_velocity
//  config   | APB psel/penable     | paddr, pwdata, prdata, pready
//
//  A velocity update runs the difference, scale, divide, saturate, MAC and
//  final states; the restoring divider retires one quotient bit per cycle,
//  and divide and saturate are skipped with no elapsed time. Reset is
//  synchronous and clears the count, the history and the filter. A new word
//  is taken while the previous result waits in the output register; a
//  stalled output holds the next word in its final state.
// ----------------------------------------------------------------------------
module encoder_position_velocity_filter_core import epvf_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic               phase_b,
  input  logic [31:0]        timestamp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] position,
  output logic signed [31:0] filtered_velocity,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [COEFF_W-1:0] filter_coeff;
  logic               invert_direction;
  epvf_cmd_t          cmd;
  epvf_status_t       status;
  reg_index_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_coeff     <= COEFF_W'(COEFF_ONE / 2);
      invert_direction <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_FILTER_COEFF:     filter_coeff     <= pwdata[COEFF_W-1:0];
        REG_INVERT_DIRECTION: invert_direction <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FILTER_COEFF:     prdata = {{(32-COEFF_W){1'b0}}, filter_coeff};
      REG_INVERT_DIRECTION: prdata = {31'b0, invert_direction};
      default:              prdata = '0;
    endcase
  end

  epvf_ctrl #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  epvf_dp #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .filter_coeff     (filter_coeff),
    .invert_direction (invert_direction),
    .req_type         (req_type),
    .phase_b          (phase_b),
    .timestamp        (timestamp),
    .position         (position),
    .filtered_velocity(filtered_velocity)
  );

endmodule
